/* rtl/core/slfs_pkg.sv */
// Shared constants, codes and types for the serpentine LED frame store.
package slfs_pkg;

	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int CNT_W   = 5;   // row_count / col_count register width
	localparam int CHAN_W  = 8;
	localparam int RGB_W   = 3 * CHAN_W;
	localparam int SUM_W   = CHAN_W + 2;
	// rows*cols fits in 10 bits for 5-bit counts; widen if the store is deeper
	localparam int TOT_W   = 2 * CNT_W;
	localparam int IDX_W   = (ADDR_W > TOT_W) ? ADDR_W : TOT_W;
	localparam int ENTRY_W = RGB_W + 1;
	localparam int BG_BIT  = RGB_W;

	localparam int ROW_W   = 4;
	localparam int COL_W   = 4;
	localparam int POS_W   = 8;

	localparam int S_DATA_W = 40;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 24;
	localparam int M_USER_W = 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [1:0] {
		FN_SET   = 2'd0,
		FN_GET   = 2'd1,
		FN_FILL  = 2'd2,
		FN_STRIP = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT = 3'd0,
		REG_COL_COUNT = 3'd1,
		REG_BG_RED    = 3'd2,
		REG_BG_GREEN  = 3'd3,
		REG_BG_BLUE   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FILL,
		ST_PUSH
	} state_t;

endpackage

/* rtl/core/serpentine_led_frame_store.sv */
// Serpentine LED frame store: one pixel memory with set, get, fill and strip read.
// Each beat on the slave side is one command; each produces exactly one beat on the
// master side. Set goes from idle straight to the push state; get and strip read pass
// through a read state for the synchronous memory read (skipped when out of range, as
// no read is made), and fill passes through a fill state, skipped for an empty matrix,
// that writes the single memory port one entry per cycle. A new command is taken only
// when the previous one has reached the output register; a result waiting there does
// not block the next command from starting. After reset every pixel reads as zero at
// once (per-entry valid flags), so no clearing pass is needed.
module serpentine_led_frame_store (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [slfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [slfs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// row[3:0], col[7:4], strip_pos[15:8], red_in[23:16], green_in[31:24], blue_in[39:32]
	input  logic [slfs_pkg::S_DATA_W-1:0]      s_axis_tdata,
	// func[1:0]
	input  logic [slfs_pkg::S_USER_W-1:0]      s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// red_out[7:0], green_out[15:8], blue_out[23:16]
	output logic [slfs_pkg::M_DATA_W-1:0]      m_axis_tdata,
	// out_of_range[0]
	output logic [slfs_pkg::M_USER_W-1:0]      m_axis_tuser
);
	import slfs_pkg::*;

	// configuration
	logic [CNT_W-1:0]  row_count_q, col_count_q;
	logic [CHAN_W-1:0] bg_red_q, bg_green_q, bg_blue_q;

	// input fields
	func_t             func;
	logic [ROW_W-1:0]  row;
	logic [COL_W-1:0]  col;
	logic [POS_W-1:0]  strip_pos;
	logic [CHAN_W-1:0] red_in, green_in, blue_in;

	// geometry
	logic [CNT_W-1:0]  rows, cols;
	logic [TOT_W-1:0]  total;
	logic              rc_ok, pos_ok;
	logic [TOT_W-1:0]  row_base;
	logic [CNT_W-1:0]  col_offs;
	logic [IDX_W-1:0]  strip_idx;
	logic [SUM_W-1:0]  px_sum, bg_sum;
	logic              accept;

	// control / datapath
	state_t            state_q, state_nxt;
	func_t             func_s1;
	logic [IDX_W-1:0]  fill_idx_q, fill_last_q;
	logic [ENTRY_W-1:0] fill_word_q;
	logic [RGB_W-1:0]  res_rgb_q;
	logic              res_oor_q;
	logic              fill_done, out_free;

	// memory
	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   vld_q;
	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  mem_addr;
	logic [ENTRY_W-1:0] mem_wd;
	logic [ENTRY_W-1:0] rd_s1;
	logic               vld_rd_s1;
	logic [ENTRY_W-1:0] rd_entry;
	logic [RGB_W-1:0]   rd_rgb;

	// output register
	logic               m_valid_q;
	logic [RGB_W-1:0]   m_rgb_q;
	logic               m_oor_q;

	assign func      = func_t'(s_axis_tuser);
	assign row       = s_axis_tdata[3:0];
	assign col       = s_axis_tdata[7:4];
	assign strip_pos = s_axis_tdata[15:8];
	assign red_in    = s_axis_tdata[23:16];
	assign green_in  = s_axis_tdata[31:24];
	assign blue_in   = s_axis_tdata[39:32];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign fill_done     = (fill_idx_q == fill_last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			col_count_q <= '0;
			bg_red_q    <= '0;
			bg_green_q  <= '0;
			bg_blue_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_COUNT: row_count_q <= cfg_data[CNT_W-1:0];
				REG_COL_COUNT: col_count_q <= cfg_data[CNT_W-1:0];
				REG_BG_RED:    bg_red_q    <= cfg_data[CHAN_W-1:0];
				REG_BG_GREEN:  bg_green_q  <= cfg_data[CHAN_W-1:0];
				REG_BG_BLUE:   bg_blue_q   <= cfg_data[CHAN_W-1:0];
				default:       ;
			endcase
		end
	end

	// Clamp to the store dimensions, then map (row, col) to the strip index:
	// rows counted from the top, so row 0 ends the strip, odd rows reversed.
	always_comb begin
		rows = (int'(row_count_q) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : row_count_q;
		cols = (int'(col_count_q) > MAX_COLS) ? CNT_W'(MAX_COLS) : col_count_q;
		total    = TOT_W'(rows) * TOT_W'(cols);
		rc_ok    = ({1'b0, row} < rows) && ({1'b0, col} < cols);
		pos_ok   = (TOT_W'(strip_pos) < total);
		row_base = TOT_W'(rows - CNT_W'(1) - CNT_W'(row)) * TOT_W'(cols);
		col_offs = row[0] ? (cols - CNT_W'(1) - CNT_W'(col)) : CNT_W'(col);
		strip_idx = IDX_W'(row_base) + IDX_W'(col_offs);
		px_sum   = SUM_W'(red_in) + SUM_W'(green_in) + SUM_W'(blue_in);
		bg_sum   = SUM_W'(bg_red_q) + SUM_W'(bg_green_q) + SUM_W'(bg_blue_q);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FN_GET:   state_nxt = rc_ok ? ST_READ : ST_PUSH;
						FN_STRIP: state_nxt = pos_ok ? ST_READ : ST_PUSH;
						FN_FILL:  state_nxt = (total == '0) ? ST_PUSH : ST_FILL;
						default:  state_nxt = ST_PUSH;
					endcase
				end
			end
			ST_READ: state_nxt = ST_PUSH;
			ST_FILL: state_nxt = fill_done ? ST_PUSH : ST_FILL;
			ST_PUSH: state_nxt = out_free ? ST_IDLE : ST_PUSH;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = strip_idx[ADDR_W-1:0];
		mem_wd   = {(px_sum <= bg_sum), red_in, green_in, blue_in};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FN_SET: mem_we = rc_ok;
						FN_GET: mem_re = rc_ok;
						FN_STRIP: begin
							mem_re   = pos_ok;
							mem_addr = ADDR_W'(IDX_W'(strip_pos));
						end
						default: ;
					endcase
				end
			end
			ST_FILL: begin
				mem_we   = 1'b1;
				mem_addr = fill_idx_q[ADDR_W-1:0];
				mem_wd   = fill_word_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wd;
		if (mem_re)
			rd_s1 <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_rd_s1 <= 1'b0;
		end else begin
			if (mem_we)
				vld_q[mem_addr] <= 1'b1;
			if (mem_re)
				vld_rd_s1 <= vld_q[mem_addr];
		end
	end

	// never-written entries read as zero (not background)
	always_comb begin
		rd_entry = vld_rd_s1 ? rd_s1 : '0;
		if (rd_entry[BG_BIT])
			rd_rgb = (func_s1 == FN_STRIP) ? {bg_red_q, bg_green_q, bg_blue_q} : '0;
		else
			rd_rgb = rd_entry[RGB_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= func;
			res_rgb_q   <= '0;
			res_oor_q   <= ((func == FN_SET) || (func == FN_GET)) ? !rc_ok :
			               (func == FN_STRIP) ? !pos_ok : 1'b0;
			fill_idx_q  <= '0;
			fill_last_q <= IDX_W'(total - TOT_W'(1));
			fill_word_q <= {(red_in == '0) && (green_in == '0) && (blue_in == '0),
			                red_in, green_in, blue_in};
		end else begin
			if (state_q == ST_READ)
				res_rgb_q <= rd_rgb;
			if (state_q == ST_FILL)
				fill_idx_q <= fill_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == ST_PUSH) && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_PUSH) && out_free) begin
			m_rgb_q <= res_rgb_q;
			m_oor_q <= res_oor_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_rgb_q[CHAN_W-1:0], m_rgb_q[2*CHAN_W-1:CHAN_W],
	                        m_rgb_q[RGB_W-1:2*CHAN_W]};
	assign m_axis_tuser  = m_oor_q;

endmodule

/* rtl/core/slfs_checker.sv */
// Port-level checks for the serpentine LED frame store, bound to the top level.
module slfs_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [slfs_pkg::M_DATA_W-1:0]      m_axis_tdata,
	input  logic [slfs_pkg::M_USER_W-1:0]      m_axis_tuser
);
	import slfs_pkg::*;

	logic       s_beat, m_beat;
	logic [1:0] pend_q;

	assign s_beat = s_axis_tvalid && s_axis_tready;
	assign m_beat = m_axis_tvalid && m_axis_tready;

	// commands taken minus results delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 2'(s_beat) - 2'(m_beat);
	end

	// a result on the output must belong to an accepted command
	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (pend_q != 2'd0))
		else $error("result beat without a pending command");

	// at most one command in flight besides a parked result
	a_bounded_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |-> (pend_q <= 2'd1))
		else $error("command accepted with two results outstanding");

	// out-of-range results carry no color
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("out-of-range result with nonzero color");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result beat changed");

endmodule

bind serpentine_led_frame_store slfs_checker u_slfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

/* verif/serpentine_led_frame_store_tb.sv */
// Self-checking testbench for the serpentine LED frame store: directed and random commands.
`timescale 1ns / 100ps

module serpentine_led_frame_store_tb;
	import slfs_pkg::*;

	localparam int STALL_LEN = 300;
	localparam int WATCHDOG  = 5000;
	// no register lives at this index; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		func_t      fn;
		logic [3:0] row;
		logic [3:0] col;
		logic [7:0] pos;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_cmd_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       oor;
	} pix_reply_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata = '0;
	logic [S_USER_W-1:0]   s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic [M_USER_W-1:0]   m_axis_tuser;

	// shadow of the pixel memory and registers
	logic [ENTRY_W-1:0] frame_mem [0:DEPTH-1];
	logic [4:0]         rows_reg = '0;
	logic [4:0]         cols_reg = '0;
	logic [7:0]         bg_r = '0;
	logic [7:0]         bg_g = '0;
	logic [7:0]         bg_b = '0;

	pix_reply_t pending_replies [$];
	int         errors = 0;
	bit         no_idle = 1'b0;
	bit         stall_request = 1'b0;

	serpentine_led_frame_store dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic int rows_eff();
		return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic int cols_eff();
		return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
	endfunction

	// odd rows run right to left, row 0 sits at the top of the strip
	function automatic int strip_addr(int r, int c, int rows, int cols);
		int base;
		base = (rows - 1 - r) * cols;
		return (r % 2 == 1) ? base + cols - 1 - c : base + c;
	endfunction

	function automatic void model_reg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		case (idx)
			REG_ROW_COUNT: rows_reg = val[4:0];
			REG_COL_COUNT: cols_reg = val[4:0];
			REG_BG_RED:    bg_r = val;
			REG_BG_GREEN:  bg_g = val;
			REG_BG_BLUE:   bg_b = val;
			default: ;
		endcase
	endfunction

	function automatic pix_reply_t predict_pixel_reply(pix_cmd_t c);
		pix_reply_t         rep;
		int                 rows, cols, total, i;
		logic [ENTRY_W-1:0] entry;
		rows = rows_eff();
		cols = cols_eff();
		total = rows * cols;
		rep = '0;
		case (c.fn)
			FN_SET: begin
				if (c.row >= rows || c.col >= cols) begin
					rep.oor = 1'b1;
				end else begin
					entry = {1'b0, c.red, c.green, c.blue};
					if (int'(c.red) + int'(c.green) + int'(c.blue) <=
					    int'(bg_r) + int'(bg_g) + int'(bg_b))
						entry[BG_BIT] = 1'b1;
					frame_mem[8'(strip_addr(int'(c.row), int'(c.col), rows, cols))] = entry;
				end
			end
			FN_GET: begin
				if (c.row >= rows || c.col >= cols) begin
					rep.oor = 1'b1;
				end else begin
					entry = frame_mem[8'(strip_addr(int'(c.row), int'(c.col), rows, cols))];
					if (!entry[BG_BIT])
						{rep.red, rep.green, rep.blue} = entry[RGB_W-1:0];
				end
			end
			FN_FILL: begin
				entry = {1'b0, c.red, c.green, c.blue};
				if (c.red == 0 && c.green == 0 && c.blue == 0)
					entry[BG_BIT] = 1'b1;
				for (i = 0; i < total; i++)
					frame_mem[8'(i)] = entry;
			end
			default: begin
				if (c.pos >= total) begin
					rep.oor = 1'b1;
				end else begin
					entry = frame_mem[c.pos];
					{rep.red, rep.green, rep.blue} = entry[BG_BIT] ? {bg_r, bg_g, bg_b}
					                                               : entry[RGB_W-1:0];
				end
			end
		endcase
		return rep;
	endfunction

	function automatic pix_cmd_t cmd(func_t fn, int row, int col, int pos,
	                                 int red, int green, int blue);
		pix_cmd_t c;
		c.fn = fn;
		c.row = 4'(row);
		c.col = 4'(col);
		c.pos = 8'(pos);
		c.red = 8'(red);
		c.green = 8'(green);
		c.blue = 8'(blue);
		return c;
	endfunction

	function automatic pix_cmd_t random_cmd(int fill_pct);
		pix_cmd_t c;
		int       rows, cols, pick;
		rows = rows_eff();
		cols = cols_eff();
		c.row = 4'($urandom_range(15));
		c.col = 4'($urandom_range(15));
		c.pos = 8'($urandom_range(255));
		c.red = 8'($urandom_range(255));
		c.green = 8'($urandom_range(255));
		c.blue = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < fill_pct)
			c.fn = FN_FILL;
		else if (pick < fill_pct + 35)
			c.fn = FN_SET;
		else if (pick < fill_pct + 60)
			c.fn = FN_GET;
		else
			c.fn = FN_STRIP;
		// most accesses land inside the matrix
		if (rows * cols > 0 && $urandom_range(99) < 88) begin
			c.row = 4'($urandom_range(rows - 1));
			c.col = 4'($urandom_range(cols - 1));
			c.pos = 8'($urandom_range(rows * cols - 1));
		end
		// dim colors sit near the background threshold
		if ($urandom_range(3) == 0) begin
			c.red = 8'($urandom_range(40));
			c.green = 8'($urandom_range(40));
			c.blue = 8'($urandom_range(40));
		end
		if (c.fn == FN_FILL && $urandom_range(2) == 0)
			{c.red, c.green, c.blue} = '0;
		return c;
	endfunction

	task automatic send_cmd(pix_cmd_t c);
		while (!no_idle && $urandom_range(99) < 7) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c.blue, c.green, c.red, c.pos, c.col, c.row};
		s_axis_tuser <= c.fn;
		do @(posedge clk); while (!s_axis_tready);
		pending_replies.push_back(predict_pixel_reply(c));
		@(negedge clk);
	endtask

	// stop offering beats and wait until every reply is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		model_reg_write(idx, val);
		@(negedge clk);
	endtask

	// upper data bits above a count field are random and must be dropped
	task automatic configure(int rows, int cols, int red, int green, int blue);
		drain();
		write_reg(REG_SPARE, 8'($urandom));
		write_reg(REG_ROW_COUNT, {3'($urandom), 5'(rows)});
		write_reg(REG_COL_COUNT, {3'($urandom), 5'(cols)});
		write_reg(REG_BG_RED, 8'(red));
		write_reg(REG_BG_GREEN, 8'(green));
		write_reg(REG_BG_BLUE, 8'(blue));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_serpentine_map();
		configure(4, 5, 10, 20, 30);
		send_cmd(cmd(FN_SET, 0, 0, 0, 200, 1, 2));
		send_cmd(cmd(FN_SET, 1, 0, 0, 100, 0, 0));
		send_cmd(cmd(FN_SET, 3, 4, 0, 255, 255, 255));
		send_cmd(cmd(FN_SET, 2, 2, 0, 10, 20, 30));   // sum equals background sum
		send_cmd(cmd(FN_SET, 2, 3, 0, 10, 20, 31));   // one above it
		send_cmd(cmd(FN_GET, 0, 0, 0, 0, 0, 0));
		send_cmd(cmd(FN_GET, 2, 2, 0, 0, 0, 0));
		send_cmd(cmd(FN_STRIP, 0, 0, 14, 0, 0, 0));
		send_cmd(cmd(FN_STRIP, 0, 0, 7, 0, 0, 0));
		send_cmd(cmd(FN_STRIP, 0, 0, 19, 0, 0, 0));
	endtask

	task automatic test_bounds();
		send_cmd(cmd(FN_SET, 4, 0, 0, 9, 9, 9));
		send_cmd(cmd(FN_SET, 15, 15, 255, 255, 255, 255));
		send_cmd(cmd(FN_GET, 0, 5, 0, 0, 0, 0));
		send_cmd(cmd(FN_STRIP, 0, 0, 20, 0, 0, 0));
		send_cmd(cmd(FN_FILL, 0, 0, 0, 0, 0, 0));
		send_cmd(cmd(FN_STRIP, 0, 0, 0, 0, 0, 0));
		send_cmd(cmd(FN_FILL, 0, 0, 0, 255, 255, 255));
		send_cmd(cmd(FN_GET, 3, 4, 0, 0, 0, 0));
		// empty matrix: every access is out of range, fill writes nothing
		configure(0, 7, 1, 2, 3);
		send_cmd(cmd(FN_SET, 0, 0, 0, 50, 60, 70));
		send_cmd(cmd(FN_GET, 0, 0, 0, 0, 0, 0));
		send_cmd(cmd(FN_STRIP, 0, 0, 0, 0, 0, 0));
		send_cmd(cmd(FN_FILL, 0, 0, 0, 1, 2, 3));
		// counts above the store size clamp to it
		configure(31, 31, 0, 0, 0);
		send_cmd(cmd(FN_SET, 15, 15, 0, 1, 1, 1));
		send_cmd(cmd(FN_GET, 15, 15, 0, 0, 0, 0));
		send_cmd(cmd(FN_STRIP, 0, 0, 255, 0, 0, 0));
		send_cmd(cmd(FN_STRIP, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_backpressure();
		configure(16, 16, $urandom_range(255), $urandom_range(255), $urandom_range(255));
		stall_request = 1'b1;
		repeat (40) send_cmd(random_cmd(0));
		drain();
	endtask

	task automatic test_random();
		int ph, rows, cols, n, fill_pct;
		for (ph = 0; ph < 9; ph++) begin
			n = 170;
			fill_pct = 4;
			case (ph)
				0: begin rows = 16; cols = 16; fill_pct = 1; end
				1: begin rows = 1;  cols = 1;  end
				2: begin rows = 16; cols = 1;  end
				3: begin rows = 1;  cols = 16; end
				4: begin rows = 31; cols = 20; fill_pct = 1; end
				5: begin rows = 0;  cols = $urandom_range(31); n = 40; end
				default: begin
					rows = $urandom_range(1, 16);
					cols = $urandom_range(1, 16);
				end
			endcase
			if (ph == 0)
				configure(rows, cols, 0, 0, 0);
			else if (ph == 1)
				configure(rows, cols, 255, 255, 255);
			else
				configure(rows, cols, $urandom_range(255), $urandom_range(255),
				          $urandom_range(255));
			no_idle = (ph == 3);
			repeat (n) send_cmd(random_cmd(fill_pct));
			no_idle = 1'b0;
		end
	endtask

	task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : reply_check
		pix_reply_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tuser[0]};
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: reply beat with none expected, actual %p", $time, got);
			end else begin
				want = pending_replies.pop_front();
				check_field("red_out", want.red, got.red);
				check_field("green_out", want.green, got.green);
				check_field("blue_out", want.blue, got.blue);
				check_field("out_of_range", 8'(want.oor), 8'(got.oor));
			end
		end
	end

	// receiver side: random stalls, plus a long hold-off on request
	initial begin : reply_sink
		forever begin
			@(negedge clk);
			if (stall_request) begin
				m_axis_tready <= 1'b0;
				repeat (STALL_LEN) @(negedge clk);
				stall_request = 1'b0;
			end else begin
				m_axis_tready <= no_idle || ($urandom_range(99) >= 7);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		foreach (frame_mem[i])
			frame_mem[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_serpentine_map();
		test_bounds();
		test_backpressure();
		test_random();
		drain();
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
